/* hdl/nvas_pkg.sv */
// shared types and constants of the vc allocator and link scheduler
// no dependencies; imported by nvas_sched and the top level

package nvas_pkg;

  localparam int NUM_VNETS_DEF   = 4;
  localparam int VC_PER_VNET_DEF = 4;

  localparam int MASK_W      = 16;
  localparam int STAMP_W     = 32;
  localparam int CREDIT_W    = 4;
  localparam int VC_ID_MAX_W = 6;
  localparam int ORDER_W     = 4;

  localparam logic [STAMP_W-1:0]  STAMP_NONE = '1;
  localparam logic [STAMP_W-1:0]  CYCLE_MAX  = 32'hFFFF_FFFE;
  localparam logic [CREDIT_W-1:0] CREDIT_MAX = '1;

  localparam logic [31:0]         THRESHOLD_RESET = 32'd50000;
  localparam logic [ORDER_W-1:0]  ORDERED_RESET   = 4'd0;
  localparam logic [CREDIT_W-1:0] BUFFERS_RESET   = 4'd4;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_ORDERED   = 2'd1;
  localparam logic [1:0] REG_BUFFERS   = 2'd2;

  typedef struct packed {
    logic                   found;
    logic [VC_ID_MAX_W-1:0] vc;
  } send_pick_t;

endpackage

/* hdl/nvas_sched.sv */
// output link scheduler: rotating priority pick over ready channels with credit,
// with the oldest-first rule inside ordered vnets; depends on nvas_pkg

module nvas_sched #(
  parameter int NUM_VNETS   = nvas_pkg::NUM_VNETS_DEF,
  parameter int VC_PER_VNET = nvas_pkg::VC_PER_VNET_DEF,
  parameter int NUM_VCS     = NUM_VNETS * VC_PER_VNET,
  parameter int NW          = (NUM_VCS > 1) ? $clog2(NUM_VCS) : 1
) (
  input  logic [NUM_VCS-1:0]                        ready,
  input  logic [NUM_VCS-1:0]                        credit_nz,
  input  logic [NUM_VCS-1:0][nvas_pkg::STAMP_W-1:0] stamp,
  input  logic [NUM_VNETS-1:0]                      ordered,
  input  logic [NW-1:0]                             start,
  output nvas_pkg::send_pick_t                      pick
);
  import nvas_pkg::*;

  logic [NUM_VCS-1:0] cand;

  for (genvar c = 0; c < NUM_VCS; c++) begin : g_vc
    localparam int VN   = c / VC_PER_VNET;
    localparam int BASE = VN * VC_PER_VNET;
    logic [VC_PER_VNET-1:0] older;
    for (genvar j = 0; j < VC_PER_VNET; j++) begin : g_peer
      assign older[j] = ready[BASE+j] && (stamp[BASE+j] < stamp[c]);
    end
    assign cand[c] = ready[c] && credit_nz[c] && !(ordered[VN] && (|older));
  end

  // first candidate at or after start, wrapping
  always_comb begin
    logic [NW:0] idx;
    pick = '0;
    for (int i = NUM_VCS - 1; i >= 0; i--) begin
      idx = {1'b0, start} + (NW+1)'(i);
      if (idx >= (NW+1)'(NUM_VCS)) begin
        idx = idx - (NW+1)'(NUM_VCS);
      end
      if (cand[idx[NW-1:0]]) begin
        pick.found = 1'b1;
        pick.vc    = VC_ID_MAX_W'(idx[NW-1:0]);
      end
    end
  end

endmodule

/* hdl/noc_ni_vc_allocator_and_scheduler.sv */
// Virtual channel allocator and output link scheduler of a network interface.
// Each transfer on the input channel is one network cycle: an optional vc request
// for a vnet, the ready and tail masks of the vc buffers and at most one returned credit.
// It yields exactly one result transfer. The block takes one item every clock
// cycle unless out_stall holds the result; an item enters an input register
// and its result is registered in the output register. The single pass between
// them holds the per-vnet round-robin idle search and the rotating priority
// pick over all channels with the stamp compares of ordered vnets. Writing
// buffers_per_vc reloads every channel's credits at once; no clearing pass.
// Depends on nvas_pkg and nvas_sched.

module noc_ni_vc_allocator_and_scheduler #(
  parameter int NUM_VNETS   = nvas_pkg::NUM_VNETS_DEF,
  parameter int VC_PER_VNET = nvas_pkg::VC_PER_VNET_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        alloc_req,
  input  logic [1:0]  alloc_vnet,
  input  logic [15:0] ready_mask,
  input  logic [15:0] tail_mask,
  input  logic        credit_valid,
  input  logic [3:0]  credit_vc,
  input  logic        credit_free,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        alloc_granted,
  output logic [3:0]  alloc_vc,
  output logic        deadlock_alarm,
  output logic        send_valid,
  output logic [3:0]  send_vc
);
  import nvas_pkg::*;

  localparam int NUM_VCS = NUM_VNETS * VC_PER_VNET;
  localparam int VW      = (VC_PER_VNET > 1) ? $clog2(VC_PER_VNET) : 1;
  localparam int NW      = (NUM_VCS > 1) ? $clog2(NUM_VCS) : 1;
  localparam int NVW     = (NUM_VNETS > 1) ? $clog2(NUM_VNETS) : 1;

  // configuration registers
  logic [31:0]         deadlock_threshold;
  logic [ORDER_W-1:0]  ordered_vnet_mask;
  logic [CREDIT_W-1:0] buffers_per_vc;
  logic                cfg_write;

  // input register
  logic              in_full;
  logic              alloc_req_r;
  logic [1:0]        alloc_vnet_r;
  logic [MASK_W-1:0] ready_r;
  logic [MASK_W-1:0] tail_r;
  logic              credit_valid_r;
  logic [3:0]        credit_vc_r;
  logic              credit_free_r;

  // channel state
  logic [NUM_VNETS-1:0][VC_PER_VNET-1:0] vc_active;
  logic [NUM_VCS-1:0][CREDIT_W-1:0]      vc_credits;
  logic [NUM_VCS-1:0][STAMP_W-1:0]       vc_stamp;
  logic [NUM_VNETS-1:0][VW-1:0]          alloc_ptr;
  logic [NUM_VNETS-1:0][31:0]            busy_count;
  logic [NW-1:0]                         rr_ptr;
  logic [STAMP_W-1:0]                    cycle_count;

  logic advance;
  logic accept;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[3:2])
      REG_THRESHOLD: prdata = deadlock_threshold;
      REG_ORDERED:   prdata = {{(32-ORDER_W){1'b0}}, ordered_vnet_mask};
      REG_BUFFERS:   prdata = {{(32-CREDIT_W){1'b0}}, buffers_per_vc};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deadlock_threshold <= THRESHOLD_RESET;
      ordered_vnet_mask  <= ORDERED_RESET;
      buffers_per_vc     <= BUFFERS_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_THRESHOLD: deadlock_threshold <= pwdata;
        REG_ORDERED:   ordered_vnet_mask  <= pwdata[ORDER_W-1:0];
        REG_BUFFERS:   buffers_per_vc     <= pwdata[CREDIT_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      alloc_req_r    <= alloc_req;
      alloc_vnet_r   <= alloc_vnet;
      ready_r        <= ready_mask;
      tail_r         <= tail_mask;
      credit_valid_r <= credit_valid;
      credit_vc_r    <= credit_vc;
      credit_free_r  <= credit_free;
    end
  end

  // allocation
  logic                   vnet_ok;
  logic [NVW-1:0]         vnet_idx;
  logic [VC_PER_VNET-1:0] idle_slice;
  logic [VW-1:0]          ptr_cur;
  logic                   idle_found;
  logic [VW-1:0]          gdelta;
  logic                   grant;
  logic [NW-1:0]          gvc;
  logic [NW+3:0]          gvc_wide;
  logic [VW-1:0]          ptr_after;
  logic [31:0]            busy_cur;
  logic [31:0]            busy_inc;
  logic                   alarm;

  assign vnet_ok    = alloc_req_r && (int'(alloc_vnet_r) < NUM_VNETS);
  assign vnet_idx   = NVW'(alloc_vnet_r);
  assign idle_slice = ~vc_active[vnet_idx];
  assign ptr_cur    = alloc_ptr[vnet_idx];

  always_comb begin
    logic [VW:0] s;
    idle_found = 1'b0;
    gdelta     = '0;
    for (int k = VC_PER_VNET - 1; k >= 0; k--) begin
      s = {1'b0, ptr_cur} + (VW+1)'(k);
      if (s >= (VW+1)'(VC_PER_VNET)) begin
        s = s - (VW+1)'(VC_PER_VNET);
      end
      if (idle_slice[s[VW-1:0]]) begin
        idle_found = 1'b1;
        gdelta     = s[VW-1:0];
      end
    end
  end

  assign grant     = vnet_ok && idle_found;
  assign gvc       = NW'(int'(vnet_idx) * VC_PER_VNET + int'(gdelta));
  assign gvc_wide  = {4'b0000, gvc};
  assign ptr_after = (gdelta == VW'(VC_PER_VNET - 1)) ? '0 : gdelta + 1'b1;

  assign busy_cur = busy_count[vnet_idx];
  assign busy_inc = (busy_cur == '1) ? busy_cur : busy_cur + 32'd1;
  assign alarm    = vnet_ok && !idle_found && (busy_inc > deadlock_threshold);

  // scheduling inputs as seen after this cycle's allocation
  logic [NUM_VCS-1:0]              grant_vec;
  logic [NUM_VCS-1:0]              ready_ext;
  logic [NUM_VCS-1:0]              tail_ext;
  logic [NUM_VCS-1:0]              credit_nz;
  logic [NUM_VCS-1:0][STAMP_W-1:0] stamp_eff;
  logic [NUM_VNETS-1:0]            ordered_ext;
  logic [NW-1:0]                   rr_next;
  send_pick_t                      pick;
  logic [NW-1:0]                   svc;
  logic [NW+3:0]                   svc_wide;
  logic [NUM_VCS-1:0]              send_vec;
  logic [NUM_VCS-1:0]              credit_hit;

  for (genvar c = 0; c < NUM_VCS; c++) begin : g_ch
    if (c < MASK_W) begin : g_in_mask
      assign ready_ext[c] = ready_r[c];
      assign tail_ext[c]  = tail_r[c];
    end else begin : g_out_mask
      assign ready_ext[c] = 1'b0;
      assign tail_ext[c]  = 1'b0;
    end
    assign grant_vec[c]  = grant && (gvc == NW'(c));
    assign credit_nz[c]  = (vc_credits[c] != '0);
    assign stamp_eff[c]  = grant_vec[c] ? cycle_count : vc_stamp[c];
    assign send_vec[c]   = pick.found && (svc == NW'(c));
    assign credit_hit[c] = credit_valid_r && (int'(credit_vc_r) == c);
  end

  for (genvar v = 0; v < NUM_VNETS; v++) begin : g_vn
    if (v < ORDER_W) begin : g_mask
      assign ordered_ext[v] = ordered_vnet_mask[v];
    end else begin : g_none
      assign ordered_ext[v] = 1'b0;
    end
  end

  assign rr_next = (rr_ptr == NW'(NUM_VCS - 1)) ? '0 : rr_ptr + 1'b1;

  nvas_sched #(
    .NUM_VNETS   (NUM_VNETS),
    .VC_PER_VNET (VC_PER_VNET)
  ) u_sched (
    .ready     (ready_ext),
    .credit_nz (credit_nz),
    .stamp     (stamp_eff),
    .ordered   (ordered_ext),
    .start     (rr_next),
    .pick      (pick)
  );

  assign svc      = pick.vc[NW-1:0];
  assign svc_wide = {4'b0000, svc};

  // per-channel next state
  logic [NUM_VCS-1:0][CREDIT_W-1:0] vc_credits_next;
  logic [NUM_VCS-1:0][STAMP_W-1:0]  vc_stamp_next;
  logic [NUM_VCS-1:0]               vc_active_next;

  always_comb begin
    logic [CREDIT_W-1:0] cr;
    for (int c = 0; c < NUM_VCS; c++) begin
      cr = send_vec[c] ? vc_credits[c] - 1'b1 : vc_credits[c];
      if (credit_hit[c] && (cr != CREDIT_MAX)) begin
        cr = cr + 1'b1;
      end
      vc_credits_next[c] = cr;

      if (send_vec[c] && tail_ext[c]) begin
        vc_stamp_next[c] = STAMP_NONE;
      end else begin
        vc_stamp_next[c] = stamp_eff[c];
      end

      if (credit_hit[c] && credit_free_r) begin
        vc_active_next[c] = 1'b0;
      end else begin
        vc_active_next[c] = grant_vec[c] || vc_active[c / VC_PER_VNET][c % VC_PER_VNET];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc_active   <= '0;
      vc_stamp    <= {NUM_VCS{STAMP_NONE}};
      vc_credits  <= {NUM_VCS{BUFFERS_RESET}};
      alloc_ptr   <= '0;
      busy_count  <= '0;
      rr_ptr      <= '0;
      cycle_count <= '0;
    end else if (cfg_write && (paddr[3:2] == REG_BUFFERS)) begin
      vc_credits <= {NUM_VCS{pwdata[CREDIT_W-1:0]}};
    end else if (advance) begin
      vc_active  <= vc_active_next;
      vc_stamp   <= vc_stamp_next;
      vc_credits <= vc_credits_next;
      rr_ptr     <= rr_next;
      if (cycle_count != CYCLE_MAX) begin
        cycle_count <= cycle_count + 32'd1;
      end
      if (grant) begin
        alloc_ptr[vnet_idx]  <= ptr_after;
        busy_count[vnet_idx] <= '0;
      end else if (vnet_ok) begin
        busy_count[vnet_idx] <= busy_inc;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      alloc_granted  <= grant;
      alloc_vc       <= grant ? gvc_wide[3:0] : 4'd0;
      deadlock_alarm <= alarm;
      send_valid     <= pick.found;
      send_vc        <= pick.found ? svc_wide[3:0] : 4'd0;
    end
  end

`ifndef ASSERT_OFF
  a_grant_no_alarm: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(alloc_granted && deadlock_alarm))
    else $error("grant and deadlock alarm in the same result");

  a_cycle_sat: assert property (@(posedge clk) disable iff (rst)
    cycle_count != STAMP_NONE)
    else $error("cycle count reached the empty stamp value");

  a_held_item: assert property (@(posedge clk) disable iff (rst)
    (in_full && !advance) |=> (in_full && $stable(ready_r) && $stable(alloc_vnet_r)))
    else $error("stalled item left the input register");

  a_send_credit: assert property (@(posedge clk) disable iff (rst)
    (advance && pick.found) |-> credit_nz[svc])
    else $error("flit scheduled on a channel without credit");
`endif

endmodule
